### hdl/ljpe_pkg.sv
package ljpe_pkg;

  // distance and scale formats
  localparam int DIST_W  = 24;
  localparam int SCALE_W = 32;
  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd1048576;

  // leading zero count of a distance word
  localparam int SHIFT_W = 5;

  // power mantissas and exponents
  localparam int MANT_W = 64;
  localparam int HALF_W = 32;
  localparam int EXP_W  = 12;

  // scale times coefficient, its upper slice
  localparam int CS_W    = 39;
  localparam int CS_HI_W = CS_W - HALF_W;

  // exact term product, clipped term
  localparam int PROD_W = MANT_W + CS_W;
  localparam int TERM_W = 60;

  // reciprocal divider: quotient bits per stage and stage count
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = 21;

  // exponent offsets
  localparam logic [EXP_W-1:0] MUL_BIAS     = 12'd63;
  localparam logic [EXP_W-1:0] U_BIAS       = 12'd66;
  localparam logic [EXP_W-1:0] TERM_BIAS    = 12'd4;
  localparam logic [EXP_W-1:0] TERM_LIM_EXP = 12'd60;

  // normalized power: value is m * 2^e, m in [2^63, 2^64), e two's complement
  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic [EXP_W-1:0]  e;
  } pf_t;

endpackage

### hdl/ljpe_mul.sv
module ljpe_mul (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  ljpe_pkg::pf_t    a_i,
  input  ljpe_pkg::pf_t    b_i,
  output ljpe_pkg::pf_t    p_o
);

  localparam int W = ljpe_pkg::MANT_W;
  localparam int H = ljpe_pkg::HALF_W;
  localparam int E = ljpe_pkg::EXP_W;

  logic [W-1:0]   p00_q, p01_q, p10_q, p11_q;
  logic [E-1:0]   ea_q, eb_q;
  logic [W-1:0]   lo_q, hi_q;
  logic [W:0]     mid_q;
  logic [2*W-1:0] full;
  logic           top;

  // first stage: four half-width partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p00_q <= a_i.m[H-1:0] * b_i.m[H-1:0];
      p01_q <= a_i.m[H-1:0] * b_i.m[W-1:H];
      p10_q <= a_i.m[W-1:H] * b_i.m[H-1:0];
      p11_q <= a_i.m[W-1:H] * b_i.m[W-1:H];
      ea_q  <= a_i.e + b_i.e + ljpe_pkg::MUL_BIAS;
    end
  end

  // second stage: fold the cross terms
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      lo_q  <= p00_q;
      hi_q  <= p11_q;
      mid_q <= {1'b0, p01_q} + {1'b0, p10_q};
      eb_q  <= ea_q;
    end
  end

  // full product, keep the top word normalized
  always_comb begin
    full  = {hi_q, lo_q} + ({{(W-1){1'b0}}, mid_q} << H);
    top   = full[2*W-1];
    p_o.m = top ? full[2*W-1:W] : full[2*W-2:W-1];
    p_o.e = eb_q + {{(E-1){1'b0}}, top};
  end

endmodule

### hdl/ljpe_term.sv
module ljpe_term (
  input  logic                          clk_i,
  input  logic [2:0]                    en_i,
  input  ljpe_pkg::pf_t                 p_i,
  input  logic [ljpe_pkg::CS_W-1:0]     cs_i,
  input  logic                          half_i,
  output logic [ljpe_pkg::TERM_W-1:0]   val_o,
  output logic                          clip_o
);

  localparam int W    = ljpe_pkg::MANT_W;
  localparam int H    = ljpe_pkg::HALF_W;
  localparam int E    = ljpe_pkg::EXP_W;
  localparam int PW   = ljpe_pkg::PROD_W;
  localparam int TW   = ljpe_pkg::TERM_W;
  localparam int CW   = ljpe_pkg::CS_W;
  localparam int SH_W = $clog2(TW);

  logic [W-1:0]     pp00_q, pp10_q;
  logic [H+ljpe_pkg::CS_HI_W-1:0] pp01_q, pp11_q;
  logic [E-1:0]     k1_q, k2_q;
  logic [PW-1:0]    prod_d, prod_q;
  logic [E-1:0]     jj, nn;
  logic [TW-1:0]    val_d, val_q;
  logic             clip_d, clip_q;

  // first stage: partial products of mantissa and scaled coefficient
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pp00_q <= p_i.m[H-1:0] * cs_i[H-1:0];
      pp01_q <= p_i.m[H-1:0] * cs_i[CW-1:H];
      pp10_q <= p_i.m[W-1:H] * cs_i[H-1:0];
      pp11_q <= p_i.m[W-1:H] * cs_i[CW-1:H];
      k1_q   <= p_i.e + ljpe_pkg::TERM_BIAS - {{(E-1){1'b0}}, half_i};
    end
  end

  // second stage: exact product
  assign prod_d = PW'(pp00_q) + (PW'(pp01_q) << H) + (PW'(pp10_q) << H)
                + (PW'(pp11_q) << W);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q <= prod_d;
      k2_q   <= k1_q;
    end
  end

  // third stage: scale to Q24.24 units, truncate, detect clipping
  always_comb begin
    jj     = ljpe_pkg::TERM_LIM_EXP - k2_q;
    nn     = '0 - k2_q;
    val_d  = '0;
    clip_d = 1'b0;
    if (prod_q != '0) begin
      if ($signed(k2_q) >= $signed(ljpe_pkg::TERM_LIM_EXP)) begin
        clip_d = 1'b1;
      end else begin
        clip_d = |(prod_q >> jj);
        if (!k2_q[E-1]) begin
          val_d = TW'(prod_q << k2_q[SH_W-1:0]);
        end else begin
          val_d = TW'(prod_q >> nn);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      val_q  <= val_d;
      clip_q <= clip_d;
    end
  end

  assign val_o  = val_q;
  assign clip_o = clip_q;

endmodule

### hdl/lennard_jones_potential_eval.sv
// Lennard-Jones 6-12 evaluator, fully pipelined.
// Input channel: in_valid_i / in_stall_o with distance_i (unsigned Q4.20).
// Output channel: out_valid_o / out_stall_i with energy_o, first_derivative_o,
// second_derivative_o (signed Q24.24, saturated) and overflow_o.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_data_i, the depth scale
// (unsigned Q12.20); ready is always high, write it only while the block is
// empty.
// Throughput is one word per cycle while the output is not stalled. A word
// passes through one input stage, one normalize stage, 21 divider stages of
// 3 quotient bits each for 1/r, one stage to form 1/r, five levels of 64x64
// mantissa multiply at 3 stages each for the powers, three stages for the
// scaled terms and one output stage.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled output only holds the words that are queued behind it; bubbles
// close up and input keeps flowing until every stage is full.
// Reset empties the pipeline and loads a scale of 1.0. A zero distance gives
// saturated results with overflow set.
module lennard_jones_potential_eval #(
  parameter int RESULT_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ljpe_pkg::DIST_W-1:0]       distance_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [RESULT_WIDTH-1:0]    energy_o,
  output logic signed [RESULT_WIDTH-1:0]    first_derivative_o,
  output logic signed [RESULT_WIDTH-1:0]    second_derivative_o,
  output logic                              overflow_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ljpe_pkg::SCALE_W-1:0]      cfg_data_i
);

  localparam int DW = ljpe_pkg::DIST_W;
  localparam int MW = ljpe_pkg::MANT_W;
  localparam int EW = ljpe_pkg::EXP_W;
  localparam int SW = ljpe_pkg::SHIFT_W;
  localparam int CW = ljpe_pkg::CS_W;
  localparam int TW = ljpe_pkg::TERM_W;

  // stage map
  localparam int ST_NRM   = 1;
  localparam int ST_DIVL  = ST_NRM + ljpe_pkg::DIV_STAGES;
  localparam int ST_U     = ST_DIVL + 1;
  localparam int ST_L1    = ST_U + 1;
  localparam int MUL_LAT  = 3;
  localparam int ST_L2    = ST_L1 + MUL_LAT;
  localparam int ST_L3    = ST_L2 + MUL_LAT;
  localparam int ST_L4    = ST_L3 + MUL_LAT;
  localparam int ST_L5    = ST_L4 + MUL_LAT;
  localparam int ST_T     = ST_L5 + MUL_LAT;
  localparam int ST_OUT   = ST_T + 3;
  localparam int NS       = ST_OUT + 1;

  localparam logic [DW-1:0] DN_MSB = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [MW-1:0] SMAX =
    {{(MW+1-RESULT_WIDTH){1'b0}}, {(RESULT_WIDTH-1){1'b1}}};
  localparam logic signed [MW-1:0] SMIN = ~SMAX;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [ST_OUT:ST_NRM] z_q;

  // ------------------------------------------------------------------
  // handshake: each stage moves when empty or when its successor moves
  always_comb begin
    en[ST_OUT] = !v_q[ST_OUT] || !out_stall_i;
    for (int k = ST_OUT - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // scale register and its coefficient multiples
  logic [ljpe_pkg::SCALE_W-1:0] scale_q;
  logic [CW-1:0] cs1_q, cs6_q, cs42_q, cs78_q;
  logic [CW-1:0] sx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ljpe_pkg::SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      scale_q <= cfg_data_i;
    end
  end

  assign sx = CW'(scale_q);

  always_ff @(posedge clk_i) begin
    cs1_q  <= sx;
    cs6_q  <= (sx << 2) + (sx << 1);
    cs42_q <= (sx << 5) + (sx << 3) + (sx << 1);
    cs78_q <= (sx << 6) + (sx << 3) + (sx << 2) + (sx << 1);
  end

  // ------------------------------------------------------------------
  // input word
  logic [DW-1:0] d_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) d_q <= distance_i;
  end

  // ------------------------------------------------------------------
  // normalize distance into [2^23, 2^24), seed the divider
  logic [SW-1:0] nrm_s;
  logic [DW-1:0] nrm_dn;
  logic          nrm_q63;

  logic [DW-1:0] dn_q  [ST_NRM:ST_DIVL];
  logic [SW-1:0] s_q   [ST_NRM:ST_DIVL];
  logic [DW-1:0] rem_q [ST_NRM:ST_DIVL];
  logic [MW-1:0] quo_q [ST_NRM:ST_DIVL];

  always_comb begin
    nrm_s = '0;
    for (int b = 0; b < DW; b++) begin
      if (d_q[b]) nrm_s = SW'(DW - 1 - b);
    end
    nrm_dn  = d_q << nrm_s;
    nrm_q63 = (nrm_dn == DN_MSB);
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_NRM]) begin
      dn_q[ST_NRM]  <= nrm_dn;
      s_q[ST_NRM]   <= nrm_s;
      rem_q[ST_NRM] <= nrm_q63 ? '0 : DN_MSB;
      quo_q[ST_NRM] <= {{(MW-1){1'b0}}, nrm_q63};
      z_q[ST_NRM]   <= (d_q == '0);
    end
  end

  // zero flag travels with the word
  for (genvar k = ST_NRM + 1; k <= ST_OUT; k++) begin : g_zero
    always_ff @(posedge clk_i) begin
      if (en[k]) z_q[k] <= z_q[k-1];
    end
  end

  // ------------------------------------------------------------------
  // restoring division of 2^86 by the normalized distance
  for (genvar k = ST_NRM + 1; k <= ST_DIVL; k++) begin : g_div
    logic [DW-1:0] r_d;
    logic [MW-1:0] q_d;
    logic [DW:0]   r2;

    always_comb begin
      r_d = rem_q[k-1];
      q_d = quo_q[k-1];
      r2  = '0;
      for (int i = 0; i < ljpe_pkg::DIV_BITS; i++) begin
        r2 = {r_d, 1'b0};
        if (r2 >= {1'b0, dn_q[k-1]}) begin
          r_d = DW'(r2 - {1'b0, dn_q[k-1]});
          q_d = {q_d[MW-2:0], 1'b1};
        end else begin
          r_d = r2[DW-1:0];
          q_d = {q_d[MW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k] <= r_d;
        quo_q[k] <= q_d;
        dn_q[k]  <= dn_q[k-1];
        s_q[k]   <= s_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // reciprocal as a normalized power
  ljpe_pkg::pf_t u_d;
  logic          u_top;

  always_comb begin
    u_top = quo_q[ST_DIVL][MW-1];
    u_d.m = u_top ? quo_q[ST_DIVL] : {quo_q[ST_DIVL][MW-2:0], 1'b0};
    u_d.e = {{(EW-SW){1'b0}}, s_q[ST_DIVL]} - ljpe_pkg::U_BIAS
          - {{(EW-1){1'b0}}, !u_top};
  end

  // ------------------------------------------------------------------
  // power delay lines, each held until its last use
  ljpe_pkg::pf_t pu_q   [ST_U:ST_L5-1];
  ljpe_pkg::pf_t pu2_q  [ST_L1+2:ST_L5-1];
  ljpe_pkg::pf_t pu4_q  [ST_L2+2:ST_L4-1];
  ljpe_pkg::pf_t pu6_q  [ST_L3+2:ST_T-1];
  ljpe_pkg::pf_t pu8_q  [ST_L3+2:ST_T-1];
  ljpe_pkg::pf_t pu7_q  [ST_L4+2:ST_T-1];
  ljpe_pkg::pf_t pu12_q [ST_L4+2:ST_T-1];
  ljpe_pkg::pf_t pu13_q [ST_L5+2:ST_T-1];
  ljpe_pkg::pf_t pu14_q [ST_L5+2:ST_T-1];

  ljpe_pkg::pf_t m_u2, m_u4, m_u6, m_u8, m_u7, m_u12, m_u13, m_u14;

  always_ff @(posedge clk_i) begin
    if (en[ST_U])    pu_q[ST_U]      <= u_d;
    if (en[ST_L1+2]) pu2_q[ST_L1+2]  <= m_u2;
    if (en[ST_L2+2]) pu4_q[ST_L2+2]  <= m_u4;
    if (en[ST_L3+2]) begin
      pu6_q[ST_L3+2] <= m_u6;
      pu8_q[ST_L3+2] <= m_u8;
    end
    if (en[ST_L4+2]) begin
      pu7_q[ST_L4+2]  <= m_u7;
      pu12_q[ST_L4+2] <= m_u12;
    end
    if (en[ST_L5+2]) begin
      pu13_q[ST_L5+2] <= m_u13;
      pu14_q[ST_L5+2] <= m_u14;
    end
  end

  for (genvar k = ST_U + 1; k <= ST_L5 - 1; k++) begin : g_pu
    always_ff @(posedge clk_i) begin
      if (en[k]) pu_q[k] <= pu_q[k-1];
    end
  end

  for (genvar k = ST_L1 + 3; k <= ST_L5 - 1; k++) begin : g_pu2
    always_ff @(posedge clk_i) begin
      if (en[k]) pu2_q[k] <= pu2_q[k-1];
    end
  end

  for (genvar k = ST_L2 + 3; k <= ST_L4 - 1; k++) begin : g_pu4
    always_ff @(posedge clk_i) begin
      if (en[k]) pu4_q[k] <= pu4_q[k-1];
    end
  end

  for (genvar k = ST_L3 + 3; k <= ST_T - 1; k++) begin : g_pu68
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pu6_q[k] <= pu6_q[k-1];
        pu8_q[k] <= pu8_q[k-1];
      end
    end
  end

  for (genvar k = ST_L4 + 3; k <= ST_T - 1; k++) begin : g_pu712
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pu7_q[k]  <= pu7_q[k-1];
        pu12_q[k] <= pu12_q[k-1];
      end
    end
  end

  for (genvar k = ST_L5 + 3; k <= ST_T - 1; k++) begin : g_pu1314
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pu13_q[k] <= pu13_q[k-1];
        pu14_q[k] <= pu14_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------------
  // power multipliers
  ljpe_mul u_mul_u2 (
    .clk_i (clk_i), .en_i ({en[ST_L1+1], en[ST_L1]}),
    .a_i (pu_q[ST_L1-1]), .b_i (pu_q[ST_L1-1]), .p_o (m_u2)
  );

  ljpe_mul u_mul_u4 (
    .clk_i (clk_i), .en_i ({en[ST_L2+1], en[ST_L2]}),
    .a_i (pu2_q[ST_L2-1]), .b_i (pu2_q[ST_L2-1]), .p_o (m_u4)
  );

  ljpe_mul u_mul_u6 (
    .clk_i (clk_i), .en_i ({en[ST_L3+1], en[ST_L3]}),
    .a_i (pu4_q[ST_L3-1]), .b_i (pu2_q[ST_L3-1]), .p_o (m_u6)
  );

  ljpe_mul u_mul_u8 (
    .clk_i (clk_i), .en_i ({en[ST_L3+1], en[ST_L3]}),
    .a_i (pu4_q[ST_L3-1]), .b_i (pu4_q[ST_L3-1]), .p_o (m_u8)
  );

  ljpe_mul u_mul_u7 (
    .clk_i (clk_i), .en_i ({en[ST_L4+1], en[ST_L4]}),
    .a_i (pu6_q[ST_L4-1]), .b_i (pu_q[ST_L4-1]), .p_o (m_u7)
  );

  ljpe_mul u_mul_u12 (
    .clk_i (clk_i), .en_i ({en[ST_L4+1], en[ST_L4]}),
    .a_i (pu8_q[ST_L4-1]), .b_i (pu4_q[ST_L4-1]), .p_o (m_u12)
  );

  ljpe_mul u_mul_u13 (
    .clk_i (clk_i), .en_i ({en[ST_L5+1], en[ST_L5]}),
    .a_i (pu12_q[ST_L5-1]), .b_i (pu_q[ST_L5-1]), .p_o (m_u13)
  );

  ljpe_mul u_mul_u14 (
    .clk_i (clk_i), .en_i ({en[ST_L5+1], en[ST_L5]}),
    .a_i (pu12_q[ST_L5-1]), .b_i (pu2_q[ST_L5-1]), .p_o (m_u14)
  );

  // ------------------------------------------------------------------
  // scaled terms
  logic [2:0]    ten;
  logic [TW-1:0] e_pos, e_neg, f_pos, f_neg, s_pos, s_neg;
  logic          e_pc, e_nc, f_pc, f_nc, s_pc, s_nc;

  assign ten = {en[ST_T+2], en[ST_T+1], en[ST_T]};

  ljpe_term u_term_e12 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu12_q[ST_T-1]), .cs_i (cs1_q),
    .half_i (1'b1), .val_o (e_pos), .clip_o (e_pc)
  );

  ljpe_term u_term_e6 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu6_q[ST_T-1]), .cs_i (cs1_q),
    .half_i (1'b0), .val_o (e_neg), .clip_o (e_nc)
  );

  ljpe_term u_term_f7 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu7_q[ST_T-1]), .cs_i (cs6_q),
    .half_i (1'b0), .val_o (f_pos), .clip_o (f_pc)
  );

  ljpe_term u_term_f13 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu13_q[ST_T-1]), .cs_i (cs6_q),
    .half_i (1'b0), .val_o (f_neg), .clip_o (f_nc)
  );

  ljpe_term u_term_s14 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu14_q[ST_T-1]), .cs_i (cs78_q),
    .half_i (1'b0), .val_o (s_pos), .clip_o (s_pc)
  );

  ljpe_term u_term_s8 (
    .clk_i (clk_i), .en_i (ten), .p_i (pu8_q[ST_T-1]), .cs_i (cs42_q),
    .half_i (1'b0), .val_o (s_neg), .clip_o (s_nc)
  );

  // ------------------------------------------------------------------
  // difference and saturation; returns {overflow, value}
  function automatic logic [RESULT_WIDTH:0] combine(
    input logic [TW-1:0] pos,
    input logic [TW-1:0] neg,
    input logic          clip,
    input logic          dom_pos
  );
    logic signed [TW:0]   diff;
    logic signed [MW-1:0] dx;
    logic [RESULT_WIDTH:0] res;
    diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
    dx   = {{(MW-TW-1){diff[TW]}}, diff};
    if (clip) begin
      res = {1'b1, dom_pos ? SMAX[RESULT_WIDTH-1:0] : SMIN[RESULT_WIDTH-1:0]};
    end else if (dx > SMAX) begin
      res = {1'b1, SMAX[RESULT_WIDTH-1:0]};
    end else if (dx < SMIN) begin
      res = {1'b1, SMIN[RESULT_WIDTH-1:0]};
    end else begin
      res = {1'b0, dx[RESULT_WIDTH-1:0]};
    end
    return res;
  endfunction

  logic [RESULT_WIDTH:0] e_res, f_res, s_res;
  logic [RESULT_WIDTH-1:0] energy_q, first_q, second_q;
  logic overflow_q;

  assign e_res = combine(e_pos, e_neg, e_pc || e_nc, 1'b1);
  assign f_res = combine(f_pos, f_neg, f_pc || f_nc, 1'b0);
  assign s_res = combine(s_pos, s_neg, s_pc || s_nc, 1'b1);

  // output word; zero distance overrides everything
  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      if (z_q[ST_OUT-1]) begin
        energy_q   <= SMAX[RESULT_WIDTH-1:0];
        first_q    <= SMIN[RESULT_WIDTH-1:0];
        second_q   <= SMAX[RESULT_WIDTH-1:0];
        overflow_q <= 1'b1;
      end else begin
        energy_q   <= e_res[RESULT_WIDTH-1:0];
        first_q    <= f_res[RESULT_WIDTH-1:0];
        second_q   <= s_res[RESULT_WIDTH-1:0];
        overflow_q <= e_res[RESULT_WIDTH] || f_res[RESULT_WIDTH]
                   || s_res[RESULT_WIDTH];
      end
    end
  end

  assign energy_o            = energy_q;
  assign first_derivative_o  = first_q;
  assign second_derivative_o = second_q;
  assign overflow_o          = overflow_q;

`ifndef SYNTHESIS
  // input stalls only when the output holds a stalled word
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled output word");

  // a taken output with a bubble behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[ST_OUT-1]) |=> !out_valid_o)
    else $error("output word repeated");

  // an accepted word occupies the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted word lost at the first stage");

  // zero distance always reports overflow
  a_zero_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && z_q[ST_OUT]) |-> overflow_o)
    else $error("zero distance without overflow");
`endif

endmodule

### tb/lennard_jones_potential_eval_test.sv
module lennard_jones_potential_eval_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RW = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [RW-1:0] energy;
    logic signed [RW-1:0] first_deriv;
    logic signed [RW-1:0] second_deriv;
    logic                 overflow;
  } lj_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [ljpe_pkg::DIST_W-1:0] distance = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [ljpe_pkg::SCALE_W-1:0] cfg_data = '0;

  logic in_stall, out_valid, overflow, cfg_ready;
  logic signed [RW-1:0] energy, first_deriv, second_deriv;

  logic [ljpe_pkg::SCALE_W-1:0] depth_scale = ljpe_pkg::SCALE_RST;
  logic [ljpe_pkg::DIST_W-1:0] pending_dist[$];
  lj_result_t expected_results[$];
  int err_count = 0;
  int cycle = 0;
  int words_in = 0;
  int words_out = 0;
  int overflow_seen = 0;

  lennard_jones_potential_eval #(.RESULT_WIDTH(RW)) uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .distance_i(distance),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .energy_o(energy), .first_derivative_o(first_deriv),
    .second_derivative_o(second_deriv), .overflow_o(overflow),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Multiply two normalized powers, keep the top 64 bits of the product
  function automatic void pow_mul(input logic [63:0] am, input int ae,
                                  input logic [63:0] bm, input int be,
                                  output logic [63:0] rm, output int re);
    logic [127:0] p;
    p = 128'(am) * 128'(bm);
    if (p[127]) begin
      rm = p[127:64];
      re = ae + be + 64;
    end else begin
      rm = p[126:63];
      re = ae + be + 63;
    end
  endfunction

  // Scaled term in Q24.24, truncated, clipped at 2^60
  function automatic logic [63:0] scaled_term(input logic [63:0] m, input int e,
                                               input int extra, input logic [63:0] c,
                                               input logic [31:0] a,
                                               inout logic clip);
    logic [127:0] p;
    logic [127:0] sh;
    int k;
    p = 128'(m) * 128'(c * 64'(a));
    if (p == 0) return 64'd0;
    k = e + extra + 4;
    if (k >= 0) begin
      if (p[127:64] != 0 || k >= 60 || (p[63:0] >> (60 - k)) != 0) begin
        clip = 1'b1;
        return 64'd1 << 60;
      end
      return p[63:0] << k;
    end
    if (-k >= 128) return 64'd0;
    sh = p >> (-k);
    if (sh[127:60] != 0) begin
      clip = 1'b1;
      return 64'd1 << 60;
    end
    return sh[63:0];
  endfunction

  // Difference of two terms, saturated to the result width
  function automatic logic signed [RW-1:0] sat_diff(input logic [63:0] pos,
                                                     input logic [63:0] neg,
                                                     input logic clip,
                                                     input logic dom_pos,
                                                     inout logic ovf);
    longint smax, smin, diff;
    smax = (longint'(1) <<< (RW - 1)) - 1;
    smin = -smax - 1;
    if (clip) begin
      ovf = 1'b1;
      diff = dom_pos ? smax : smin;
    end else begin
      diff = longint'(pos) - longint'(neg);
      if (diff > smax) begin
        diff = smax;
        ovf = 1'b1;
      end
      if (diff < smin) begin
        diff = smin;
        ovf = 1'b1;
      end
    end
    return diff[RW-1:0];
  endfunction

  // Potential and derivatives of one distance under the current scale
  function automatic lj_result_t lj_eval(input logic [ljpe_pkg::DIST_W-1:0] d,
                                          input logic [ljpe_pkg::SCALE_W-1:0] a);
    lj_result_t r;
    logic [127:0] dn;
    logic [127:0] q;
    logic [63:0] um, u2m, u4m, u6m, u7m, u8m, u12m, u13m, u14m, t1, t2;
    int ue, u2e, u4e, u6e, u7e, u8e, u12e, u13e, u14e, s;
    logic clip, ovf;
    if (d == 0) begin
      r.energy = {1'b0, {(RW-1){1'b1}}};
      r.first_deriv = {1'b1, {(RW-1){1'b0}}};
      r.second_deriv = {1'b0, {(RW-1){1'b1}}};
      r.overflow = 1'b1;
      return r;
    end
    dn = 128'(d);
    s = 0;
    while (dn < (128'd1 << 23)) begin
      dn = dn << 1;
      s++;
    end
    q = (128'd1 << 86) / dn;
    um = q[63:0];
    ue = s - 66;
    if (!um[63]) begin
      um = um << 1;
      ue--;
    end
    pow_mul(um, ue, um, ue, u2m, u2e);
    pow_mul(u2m, u2e, u2m, u2e, u4m, u4e);
    pow_mul(u4m, u4e, u2m, u2e, u6m, u6e);
    pow_mul(u6m, u6e, um, ue, u7m, u7e);
    pow_mul(u4m, u4e, u4m, u4e, u8m, u8e);
    pow_mul(u8m, u8e, u4m, u4e, u12m, u12e);
    pow_mul(u12m, u12e, um, ue, u13m, u13e);
    pow_mul(u12m, u12e, u2m, u2e, u14m, u14e);
    ovf = 1'b0;
    clip = 1'b0;
    t1 = scaled_term(u12m, u12e, -1, 64'd1, a, clip);
    t2 = scaled_term(u6m, u6e, 0, 64'd1, a, clip);
    r.energy = sat_diff(t1, t2, clip, 1'b1, ovf);
    clip = 1'b0;
    t1 = scaled_term(u7m, u7e, 0, 64'd6, a, clip);
    t2 = scaled_term(u13m, u13e, 0, 64'd6, a, clip);
    r.first_deriv = sat_diff(t1, t2, clip, 1'b0, ovf);
    clip = 1'b0;
    t1 = scaled_term(u14m, u14e, 0, 64'd78, a, clip);
    t2 = scaled_term(u8m, u8e, 0, 64'd42, a, clip);
    r.second_deriv = sat_diff(t1, t2, clip, 1'b1, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  // Hold off idling in one long stretch of the run
  function automatic logic idle_now();
    if (cycle >= 3000 && cycle < 6000) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  // Drive distance words, record the expectation of each accepted word
  always @(posedge clk) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(lj_eval(distance, depth_scale));
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_dist.size() > 0 && !idle_now()) begin
          in_valid <= 1'b1;
          distance <= pending_dist.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    lj_result_t exp_r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
      if (out_valid && !out_stall) begin
        words_out++;
        if (overflow) overflow_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with no expectation pending");
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (energy !== exp_r.energy) begin
            $error("energy: expected %0d, got %0d", exp_r.energy, energy);
            err_count++;
          end
          if (first_deriv !== exp_r.first_deriv) begin
            $error("first_derivative: expected %0d, got %0d",
                   exp_r.first_deriv, first_deriv);
            err_count++;
          end
          if (second_deriv !== exp_r.second_deriv) begin
            $error("second_derivative: expected %0d, got %0d",
                   exp_r.second_deriv, second_deriv);
            err_count++;
          end
          if (overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, got %0b", exp_r.overflow, overflow);
            err_count++;
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("lennard_jones_potential_eval: mismatch");
      $finish;
    end
  end

  task automatic write_scale(input logic [ljpe_pkg::SCALE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    depth_scale = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_dist.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic queue_directed();
    pending_dist.push_back(24'd0);
    pending_dist.push_back(24'd1);
    pending_dist.push_back(24'hFFFFFF);
    pending_dist.push_back(24'h800000);
    pending_dist.push_back(24'h7FFFFF);
    pending_dist.push_back(24'h100000);
    pending_dist.push_back(24'h11F59B);
    pending_dist.push_back(24'h080000);
    pending_dist.push_back(24'h0C0000);
    pending_dist.push_back(24'h000400);
    pending_dist.push_back(24'h555555);
    pending_dist.push_back(24'hAAAAAA);
  endtask

  task automatic queue_random(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(9);
      // mostly the physical range around the well, some full-range noise and some short distances
      if (pick < 6) pending_dist.push_back(24'($urandom_range(24'h300000, 24'h0C0000)));
      else if (pick < 8) pending_dist.push_back(24'($urandom));
      else pending_dist.push_back(24'($urandom_range(24'h0C0000, 1)));
    end
  endtask

  initial begin
    logic [ljpe_pkg::SCALE_W-1:0] scales[5];
    scales[0] = ljpe_pkg::SCALE_RST;
    scales[1] = 32'hFFFFFFFF;
    scales[2] = 32'd0;
    scales[3] = $urandom;
    scales[4] = 32'($urandom_range(32'h00200000, 1));
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    foreach (scales[i]) begin
      write_scale(scales[i]);
      queue_directed();
      queue_random(218);
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d distance words over 5 scale settings incl. 0 and all-ones",
             words_in);
    $display("checked %0d result words, %0d with overflow set", words_out, overflow_seen);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("lennard_jones_potential_eval: match");
    end else begin
      $display("lennard_jones_potential_eval: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ljpe_pkg.sv
hdl/ljpe_mul.sv
hdl/ljpe_term.sv
hdl/lennard_jones_potential_eval.sv
tb/lennard_jones_potential_eval_test.sv
